// ===== sv/pjt_pkg.sv =====
// Types and codes shared by the job table cells and the top level.
package pjt_pkg;

   // Field widths fixed by the stream payload.
   localparam int CMD_W  = 3;
   localparam int ID_W   = 11;
   localparam int TAG_W  = 32;
   localparam int PRIO_W = 16;
   localparam int WRK_W  = 8;
   localparam int CNT_W  = 11;
   localparam int CODE_W = 3;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 112;

   // Commands.
   localparam logic [CMD_W-1:0] CMD_ENQUEUE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_CLAIM    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_COMPLETE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FAIL     = 3'd3;

   // Result codes.
   localparam logic [CODE_W-1:0] RES_QUEUED    = 3'd0;
   localparam logic [CODE_W-1:0] RES_CLAIMED   = 3'd1;
   localparam logic [CODE_W-1:0] RES_EMPTY     = 3'd2;
   localparam logic [CODE_W-1:0] RES_UPDATED   = 3'd3;
   localparam logic [CODE_W-1:0] RES_NOT_FOUND = 3'd4;
   localparam logic [CODE_W-1:0] RES_FULL      = 3'd5;
   localparam logic [CODE_W-1:0] RES_STATS     = 3'd6;

   // Entry status.
   localparam logic [1:0] ST_QUEUED    = 2'd0;
   localparam logic [1:0] ST_CLAIMED   = 2'd1;
   localparam logic [1:0] ST_COMPLETED = 2'd2;
   localparam logic [1:0] ST_FAILED    = 2'd3;

   typedef enum logic {
      SCAN_CLAIM,
      SCAN_LOOKUP
   } scan_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_FILL,
      WR_STATUS
   } wr_op_type;

   // Running result carried from cell to cell.
   typedef struct packed {
      logic                     found;
      logic [1:0]               status;
      logic signed [PRIO_W-1:0] prio;
      logic [TAG_W-1:0]         tag;
   } token_type;

   // Write broadcast to the row.
   typedef struct packed {
      wr_op_type                op;
      logic [1:0]               status;
      logic signed [PRIO_W-1:0] prio;
      logic [TAG_W-1:0]         tag;
   } wr_type;

endpackage

// ===== sv/pjt_cell.sv =====
// One table entry with its stage of the search chain.
module pjt_cell import pjt_pkg::*; #(
   parameter int SW    = 10,
   parameter int CW    = 11,
   parameter int INDEX = 0
) (
   input  logic          clock,
   input  scan_type      mode,
   input  logic [CW-1:0] count,
   input  logic [SW-1:0] target,
   input  token_type     tok_in,
   input  logic [SW-1:0] slot_in,
   output token_type     tok_out,
   output logic [SW-1:0] slot_out,
   input  wr_type        wr,
   input  logic [SW-1:0] wr_slot
);

   logic [1:0]               status_ff;
   logic signed [PRIO_W-1:0] prio_ff;
   logic [TAG_W-1:0]         tag_ff;
   token_type                tok_ff, tok_in_w;
   logic [SW-1:0]            slot_ff, slot_in_w;
   logic                     here, take;

   assign here = CW'(INDEX) < count;

   always_comb begin
      take = 1'b0;
      case (mode)
         SCAN_CLAIM: begin
            take = here && status_ff == ST_QUEUED
                   && (!tok_in.found || prio_ff < tok_in.prio);
         end
         SCAN_LOOKUP: begin
            take = here && SW'(INDEX) == target;
         end
         default: begin
            take = 1'b0;
         end
      endcase
      tok_in_w  = tok_in;
      slot_in_w = slot_in;
      if (take) begin
         tok_in_w.found  = 1'b1;
         tok_in_w.status = status_ff;
         tok_in_w.prio   = prio_ff;
         tok_in_w.tag    = tag_ff;
         slot_in_w       = SW'(INDEX);
      end
   end

   always_ff @(posedge clock) begin
      tok_ff  <= tok_in_w;
      slot_ff <= slot_in_w;
      if (wr_slot == SW'(INDEX)) begin
         case (wr.op)
            WR_FILL: begin
               status_ff <= wr.status;
               prio_ff   <= wr.prio;
               tag_ff    <= wr.tag;
            end
            WR_STATUS: begin
               status_ff <= wr.status;
            end
            default: begin
            end
         endcase
      end
   end

   assign tok_out  = tok_ff;
   assign slot_out = slot_ff;

endmodule

// ===== sv/priority_job_table.sv =====
// Top level of the priority job table: command decode, counters and the cell row.
//
// Commands arrive as transfers on the req_ channel (tuser = command, tdata = job id,
// tag, priority, worker); one result transfer per command leaves on the rsp_ channel
// (tuser = result code, tdata = id, tag, worker and the five counts after the command).
// Enqueue, stats and complete/fail with an unknown id finish on the accepting edge:
// the result is registered there and shows in the cycle after acceptance.
// Claim, complete and fail with a known id pass a search token down the row of
// CAPACITY cells, one cell per cycle, before the result is registered; the length
// of the cell row sets how long the sweep lasts.
// One command is worked on at a time. A new command is taken once the block is idle
// and the result register is empty or being drained in the same cycle.
// When the receiver stalls, hold the result and its counts; the block waits.
// Reset clears the counts, the fill count and the control state; entry storage is
// left as it is and is only read below the fill count, so no clearing pass is needed.
module priority_job_table import pjt_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // job_id [10:0], job_tag [42:11], priority_req [58:43], worker_id [66:59]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd [2:0]
   input  logic [CMD_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // result_id [10:0], result_tag [42:11], result_worker [50:43], total_count [61:51],
   // queued_count [72:62], claimed_count [83:73], completed_count [94:84],
   // failed_count [105:95]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // result_code [2:0]
   output logic [CODE_W-1:0]     rsp_tuser
);

   localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > ID_W) ? CW + 1 : ID_W + 1;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SWEEP = 3'b010,
      S_DONE  = 3'b100
   } state_type;

   function automatic logic [ID_W-1:0] to_id(input logic [XW-1:0] v);
      return v[ID_W-1:0];
   endfunction

   // Request fields.
   logic [ID_W-1:0]          job_id;
   logic [TAG_W-1:0]         job_tag;
   logic signed [PRIO_W-1:0] priority_req;
   logic [WRK_W-1:0]         worker_id;

   assign job_id       = req_tdata[10:0];
   assign job_tag      = req_tdata[42:11];
   assign priority_req = req_tdata[58:43];
   assign worker_id    = req_tdata[66:59];

   state_type         state_ff, state_in;
   logic [SW-1:0]     cnt_ff, cnt_in;
   scan_type          mode_ff, mode_in;
   logic [SW-1:0]     target_ff, target_in;
   logic [ID_W-1:0]   jid_ff, jid_in;
   logic [1:0]        new_st_ff, new_st_in;
   logic [WRK_W-1:0]  wrk_ff, wrk_in;
   logic [CW-1:0]     total_ff, total_in;
   logic [CW-1:0]     stat_cnt_ff [4];
   logic [CW-1:0]     stat_cnt_in [4];
   logic [3:0]        inc, dec;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [ID_W-1:0]   rid_ff, rid_in;
   logic [TAG_W-1:0]  rtag_ff, rtag_in;
   logic [WRK_W-1:0]  rwrk_ff, rwrk_in;

   logic              out_free, accept, load, jid_ok;
   logic [XW-1:0]     jid_x;
   wr_type            wr;
   logic [SW-1:0]     wr_slot;

   token_type         tok_w  [CAPACITY+1];
   logic [SW-1:0]     slot_w [CAPACITY+1];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign jid_x      = XW'(job_id);
   assign jid_ok     = job_id != '0 && jid_x <= XW'(total_ff);

   // Cell row: the token enters empty at the head and leaves at the tail.
   assign tok_w[0]  = '0;
   assign slot_w[0] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      pjt_cell #(
         .SW    (SW),
         .CW    (CW),
         .INDEX (i)
      ) u_cell (
         .clock    (clock),
         .mode     (mode_ff),
         .count    (total_ff),
         .target   (target_ff),
         .tok_in   (tok_w[i]),
         .slot_in  (slot_w[i]),
         .tok_out  (tok_w[i+1]),
         .slot_out (slot_w[i+1]),
         .wr       (wr),
         .wr_slot  (wr_slot)
      );
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      mode_in   = mode_ff;
      target_in = target_ff;
      jid_in    = jid_ff;
      new_st_in = new_st_ff;
      wrk_in    = wrk_ff;
      total_in  = total_ff;
      inc       = '0;
      dec       = '0;
      load      = 1'b0;
      code_in   = code_ff;
      rid_in    = rid_ff;
      rtag_in   = rtag_ff;
      rwrk_in   = rwrk_ff;
      wr        = '0;
      wr.op     = WR_NONE;
      wr_slot   = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rid_in  = '0;
               rtag_in = '0;
               rwrk_in = '0;
               case (req_tuser)
                  CMD_ENQUEUE: begin
                     load = 1'b1;
                     if (XW'(total_ff) >= XW'(CAPACITY)) begin
                        code_in = RES_FULL;
                     end else begin
                        wr.op          = WR_FILL;
                        wr.status      = ST_QUEUED;
                        wr.prio        = priority_req;
                        wr.tag         = job_tag;
                        wr_slot        = total_ff[SW-1:0];
                        total_in       = total_ff + 1'b1;
                        inc[ST_QUEUED] = 1'b1;
                        code_in        = RES_QUEUED;
                        rid_in         = to_id(XW'(total_ff) + XW'(1));
                        rtag_in        = job_tag;
                     end
                  end
                  CMD_CLAIM: begin
                     mode_in  = SCAN_CLAIM;
                     wrk_in   = worker_id;
                     cnt_in   = '0;
                     state_in = S_SWEEP;
                  end
                  CMD_COMPLETE, CMD_FAIL: begin
                     if (jid_ok) begin
                        mode_in   = SCAN_LOOKUP;
                        target_in = SW'(jid_x - XW'(1));
                        jid_in    = job_id;
                        new_st_in = (req_tuser == CMD_COMPLETE) ? ST_COMPLETED : ST_FAILED;
                        cnt_in    = '0;
                        state_in  = S_SWEEP;
                     end else begin
                        load    = 1'b1;
                        code_in = RES_NOT_FOUND;
                     end
                  end
                  default: begin
                     load    = 1'b1;
                     code_in = RES_STATS;
                  end
               endcase
            end
         end
         S_SWEEP: begin
            // Advance until the token has passed the last cell.
            if (cnt_ff == SW'(CAPACITY - 1)) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = S_IDLE;
               rid_in   = '0;
               rtag_in  = '0;
               rwrk_in  = '0;
               case (mode_ff)
                  SCAN_CLAIM: begin
                     if (tok_w[CAPACITY].found) begin
                        wr.op           = WR_STATUS;
                        wr.status       = ST_CLAIMED;
                        wr_slot         = slot_w[CAPACITY];
                        dec[ST_QUEUED]  = 1'b1;
                        inc[ST_CLAIMED] = 1'b1;
                        code_in         = RES_CLAIMED;
                        rid_in          = to_id(XW'(slot_w[CAPACITY]) + XW'(1));
                        rtag_in         = tok_w[CAPACITY].tag;
                        rwrk_in         = wrk_ff;
                     end else begin
                        code_in = RES_EMPTY;
                     end
                  end
                  default: begin
                     wr.op                       = WR_STATUS;
                     wr.status                   = new_st_ff;
                     wr_slot                     = target_ff;
                     dec[tok_w[CAPACITY].status] = 1'b1;
                     inc[new_st_ff]              = 1'b1;
                     code_in                     = RES_UPDATED;
                     rid_in                      = jid_ff;
                     rtag_in                     = tok_w[CAPACITY].tag;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Drop the old status count, then add the new one.
      for (int k = 0; k < 4; k++) begin
         stat_cnt_in[k] = stat_cnt_ff[k];
         if (dec[k] && stat_cnt_ff[k] != '0) begin
            stat_cnt_in[k] = stat_cnt_in[k] - 1'b1;
         end
         if (inc[k]) begin
            stat_cnt_in[k] = stat_cnt_in[k] + 1'b1;
         end
      end

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         for (int k = 0; k < 4; k++) begin
            stat_cnt_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         for (int k = 0; k < 4; k++) begin
            stat_cnt_ff[k] <= stat_cnt_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      mode_ff   <= mode_in;
      target_ff <= target_in;
      jid_ff    <= jid_in;
      new_st_ff <= new_st_in;
      wrk_ff    <= wrk_in;
      code_ff   <= code_in;
      rid_ff    <= rid_in;
      rtag_ff   <= rtag_in;
      rwrk_ff   <= rwrk_in;
   end

   // Counts are live: none can change while a result waits for its transfer.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = code_ff;
   assign rsp_tdata  = {6'd0,
                        to_id(XW'(stat_cnt_ff[ST_FAILED])),
                        to_id(XW'(stat_cnt_ff[ST_COMPLETED])),
                        to_id(XW'(stat_cnt_ff[ST_CLAIMED])),
                        to_id(XW'(stat_cnt_ff[ST_QUEUED])),
                        to_id(XW'(total_ff)),
                        rwrk_ff,
                        rtag_ff,
                        rid_ff};

endmodule
